FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define NDS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nds assertion failed");

// next-cycle implication, disabled while reset is asserted
`define NDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nds assertion failed");

`endif

FILE: rtl/core/nds_pkg.sv
// Package: widths, opcodes and controller/datapath interface types.
package nds_pkg;

    localparam int MAX_AGENTS = 1024;
    localparam int AW         = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int CW         = $clog2(MAX_AGENTS + 1);
    localparam int PAIR_MAX   = MAX_AGENTS * (MAX_AGENTS - 1) / 2;
    localparam int PW         = $clog2(PAIR_MAX + 1);

    localparam int POS_W      = 16;
    localparam int VEL_W      = 16;
    localparam int MAG_W      = 16;
    localparam int RAD_W      = 17;
    localparam int ROOT_W     = 17;
    localparam int SQ_W       = 2 * ROOT_W;

    localparam int SSUM_W     = MAG_W + CW;
    localparam int SSQ_W      = 2 * MAG_W + CW;
    localparam int DSUM_W     = ROOT_W + PW;
    localparam int DSQ_W      = SQ_W + PW;
    localparam int DIV_W      = (DSQ_W > SSQ_W) ? DSQ_W : SSQ_W;
    localparam int DVS_W      = (PW > CW) ? PW : CW;

    localparam int MEAN_D_W   = 17;
    localparam int MEAN_S_W   = 16;
    localparam int PC_W       = 19;

    localparam int IN_TDATA_W   = 64;
    localparam int OUT_FIELDS_W = 2 * MEAN_D_W + 2 * MEAN_S_W + PC_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1600);

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQX,
        OP_SQY,
        OP_RT_GO,
        OP_ACC,
        OP_ACCSQ,
        OP_WINIT,
        OP_PRD,
        OP_PDIFF,
        OP_PNEXT,
        OP_DIV_SUM,
        OP_MEAN,
        OP_DIV_SQ,
        OP_VPREP,
        OP_VAR,
        OP_RMS,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic sel_dist;
    } cmd_t;

    typedef struct packed {
        logic stored;
        logic last;
        logic cnt_ge2;
        logic has_pairs;
        logic walk_end;
        logic qualify;
        logic sqrt_busy;
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/core/nds_sqrt.sv
// Iterative integer square root, one result bit per cycle, truncating.
module nds_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nds_pkg::SQ_W-1:0]    operand,
    output logic                        busy,
    output logic [nds_pkg::ROOT_W-1:0]  root
);
    import nds_pkg::*;

    localparam int SW     = SQ_W + 1;
    localparam int STEP_W = $clog2(ROOT_W + 1);
    localparam logic [SW-1:0] B_INIT = SW'(1) << (SQ_W - 2);

    logic [SW-1:0]     v_reg;
    logic [SW-1:0]     r_reg;
    logic [SW-1:0]     b_reg;
    logic [SW-1:0]     trial;
    logic              fit;
    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;

    assign trial = r_reg + b_reg;
    assign fit   = (v_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= SW'(operand);
            r_reg <= '0;
            b_reg <= B_INIT;
        end
        else if (busy_reg)
        begin
            if (fit)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

FILE: rtl/core/nds_div.sv
// Restoring divider, one quotient bit per cycle, truncating.
module nds_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [nds_pkg::DIV_W-1:0]  dividend,
    input  logic [nds_pkg::DVS_W-1:0]  divisor,
    output logic                       busy,
    output logic [nds_pkg::DIV_W-1:0]  quot
);
    import nds_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  q_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  d_reg;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;
    logic              ge;
    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;

    assign shifted = {rem_reg, q_reg[DIV_W-1]};
    assign ge      = (shifted >= {1'b0, d_reg});
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            q_reg   <= {q_reg[DIV_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

FILE: rtl/core/nds_datapath.sv
// Datapath: position stores, accumulators, shared squarer, root and divide units.
module nds_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nds_pkg::cmd_t                    cmd,
    output nds_pkg::stat_t                   stat,
    input  logic [nds_pkg::IN_TDATA_W-1:0]   in_tdata,
    input  logic                             in_tlast,
    input  logic                             cfg_we,
    input  logic [nds_pkg::RAD_W-1:0]        cfg_wdata,
    input  logic                             out_tready,
    output logic                             out_tvalid,
    output logic [nds_pkg::OUT_TDATA_W-1:0]  out_tdata,
    output logic                             out_tuser
);
    import nds_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

    logic [POS_W-1:0]  x_mem [MAX_AGENTS];
    logic [POS_W-1:0]  y_mem [MAX_AGENTS];

    logic [CW-1:0]     cnt_reg;
    logic              ovf_reg;
    logic              last_reg;
    logic              stored_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic [SQ_W-1:0]   r2_reg;
    logic [MAG_W-1:0]  ax_reg;
    logic [MAG_W-1:0]  ay_reg;
    logic [SQ_W-1:0]   t_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SSUM_W-1:0] ssum_reg;
    logic [SSQ_W-1:0]  ssq_reg;
    logic [DSUM_W-1:0] dsum_reg;
    logic [DSQ_W-1:0]  dsq_reg;
    logic [PW-1:0]     pairs_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic [POS_W-1:0]  xi_reg;
    logic [POS_W-1:0]  yi_reg;
    logic [POS_W-1:0]  xj_reg;
    logic [POS_W-1:0]  yj_reg;
    logic [ROOT_W-1:0] mean_reg;
    logic [SQ_W-1:0]   msq_reg;
    logic [MEAN_D_W-1:0] res_mean_d_reg;
    logic [MEAN_D_W-1:0] res_rms_d_reg;
    logic [MEAN_S_W-1:0] res_mean_s_reg;
    logic [MEAN_S_W-1:0] res_rms_s_reg;
    logic              out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic              out_user_reg;

    logic [POS_W-1:0]  in_x;
    logic [POS_W-1:0]  in_y;
    logic [VEL_W-1:0]  in_vx;
    logic [VEL_W-1:0]  in_vy;
    logic              room;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic [ROOT_W-1:0] mul_a;
    logic [SQ_W-1:0]   prod;
    logic [ROOT_W-1:0] root;
    logic              sqrt_busy;
    logic              div_busy;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  quot;

    function automatic logic [MAG_W-1:0] mag(input logic [VEL_W-1:0] v);
        mag = v[VEL_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    endfunction

    function automatic logic [MAG_W-1:0] absdiff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign in_x  = in_tdata[POS_W-1:0];
    assign in_y  = in_tdata[2*POS_W-1:POS_W];
    assign in_vx = in_tdata[2*POS_W+VEL_W-1:2*POS_W];
    assign in_vy = in_tdata[2*POS_W+2*VEL_W-1:2*POS_W+VEL_W];

    assign room   = (cnt_reg < CW'(MAX_AGENTS));
    assign cnt_m1 = cnt_reg - CW'(1);
    assign cnt_m2 = cnt_reg - CW'(2);

    always_comb
    begin
        case (cmd.op)
            OP_SQX:   mul_a = ROOT_W'(ax_reg);
            OP_SQY:   mul_a = ROOT_W'(ay_reg);
            OP_ACC:   mul_a = root;
            OP_WINIT: mul_a = ROOT_W'(radius_reg);
            OP_VPREP: mul_a = mean_reg;
            default:  mul_a = '0;
        endcase
    end

    assign prod = mul_a * mul_a;

    always_comb
    begin
        if (cmd.sel_dist)
        begin
            div_dividend = (cmd.op == OP_DIV_SUM) ? DIV_W'(dsum_reg) : DIV_W'(dsq_reg);
            div_divisor  = DVS_W'(pairs_reg);
        end
        else
        begin
            div_dividend = (cmd.op == OP_DIV_SUM) ? DIV_W'(ssum_reg) : DIV_W'(ssq_reg);
            div_divisor  = DVS_W'(cnt_reg);
        end
    end

    assign div_start = (cmd.op == OP_DIV_SUM) || (cmd.op == OP_DIV_SQ);

    nds_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.op == OP_RT_GO),
        .operand (sq_reg),
        .busy    (sqrt_busy),
        .root    (root)
    );

    nds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quot     (quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && room)
        begin
            x_mem[cnt_reg[AW-1:0]] <= in_x;
            y_mem[cnt_reg[AW-1:0]] <= in_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PRD)
        begin
            xi_reg <= x_mem[i_reg[AW-1:0]];
            yi_reg <= y_mem[i_reg[AW-1:0]];
            xj_reg <= x_mem[j_reg[AW-1:0]];
            yj_reg <= y_mem[j_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            ssum_reg      <= '0;
            ssq_reg       <= '0;
            dsum_reg      <= '0;
            dsq_reg       <= '0;
            pairs_reg     <= '0;
            radius_reg    <= RADIUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    if (room)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                OP_ACC:
                begin
                    if (cmd.sel_dist)
                    begin
                        dsum_reg  <= dsum_reg + DSUM_W'(root);
                        pairs_reg <= pairs_reg + PW'(1);
                    end
                    else
                    begin
                        ssum_reg <= ssum_reg + SSUM_W'(root);
                    end
                end
                OP_ACCSQ:
                begin
                    if (cmd.sel_dist)
                    begin
                        dsq_reg <= dsq_reg + DSQ_W'(t_reg);
                    end
                    else
                    begin
                        ssq_reg <= ssq_reg + SSQ_W'(t_reg);
                    end
                end
                OP_EMIT:
                begin
                    cnt_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    ssum_reg      <= '0;
                    ssq_reg       <= '0;
                    dsum_reg      <= '0;
                    dsq_reg       <= '0;
                    pairs_reg     <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                ax_reg     <= mag(in_vx);
                ay_reg     <= mag(in_vy);
                last_reg   <= in_tlast;
                stored_reg <= room;
            end
            OP_SQX:
            begin
                t_reg <= prod;
            end
            OP_SQY:
            begin
                sq_reg <= t_reg + prod;
            end
            OP_ACC:
            begin
                t_reg <= prod;
            end
            OP_WINIT:
            begin
                r2_reg         <= prod;
                i_reg          <= '0;
                j_reg          <= CW'(1);
                res_mean_d_reg <= '0;
                res_rms_d_reg  <= '0;
                res_mean_s_reg <= '0;
                res_rms_s_reg  <= '0;
            end
            OP_PDIFF:
            begin
                ax_reg <= absdiff(xi_reg, xj_reg);
                ay_reg <= absdiff(yi_reg, yj_reg);
            end
            OP_PNEXT:
            begin
                if (j_reg == cnt_m1)
                begin
                    i_reg <= i_reg + CW'(1);
                    j_reg <= i_reg + CW'(2);
                end
                else
                begin
                    j_reg <= j_reg + CW'(1);
                end
            end
            OP_MEAN:
            begin
                mean_reg <= quot[ROOT_W-1:0];
                if (cmd.sel_dist)
                begin
                    res_mean_d_reg <= quot[MEAN_D_W-1:0];
                end
                else
                begin
                    res_mean_s_reg <= quot[MEAN_S_W-1:0];
                end
            end
            OP_VPREP:
            begin
                msq_reg <= quot[SQ_W-1:0];
                t_reg   <= prod;
            end
            OP_VAR:
            begin
                sq_reg <= (msq_reg > t_reg) ? (msq_reg - t_reg) : '0;
            end
            OP_RMS:
            begin
                if (cmd.sel_dist)
                begin
                    res_rms_d_reg <= root[MEAN_D_W-1:0];
                end
                else
                begin
                    res_rms_s_reg <= root[MEAN_S_W-1:0];
                end
            end
            OP_EMIT:
            begin
                out_data_reg <= {{PAD_W{1'b0}}, PC_W'(pairs_reg), res_rms_s_reg,
                                 res_mean_s_reg, res_rms_d_reg, res_mean_d_reg};
                out_user_reg <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.stored    = stored_reg;
    assign stat.last      = last_reg;
    assign stat.cnt_ge2   = (cnt_reg >= CW'(2));
    assign stat.has_pairs = (pairs_reg != '0);
    assign stat.walk_end  = (j_reg == cnt_m1) && (i_reg == cnt_m2);
    assign stat.qualify   = (sq_reg != '0) && (sq_reg <= r2_reg);
    assign stat.sqrt_busy = sqrt_busy;
    assign stat.div_busy  = div_busy;
    assign stat.out_free  = !out_valid_reg || out_tready;

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;
    assign out_tuser  = out_user_reg;

endmodule

FILE: rtl/core/nds_ctrl.sv
// Controller: sequences loading, the pair walk and the final statistics.
module nds_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_tvalid,
    output logic           in_tready,
    output nds_pkg::cmd_t  cmd,
    input  nds_pkg::stat_t stat
);
    import nds_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE   = 22'h000001,
        S_LOADED = 22'h000002,
        S_SQX    = 22'h000004,
        S_SQY    = 22'h000008,
        S_PCHK   = 22'h000010,
        S_RT     = 22'h000020,
        S_RTW    = 22'h000040,
        S_ACC    = 22'h000080,
        S_ACCSQ  = 22'h000100,
        S_WINIT  = 22'h000200,
        S_PRD    = 22'h000400,
        S_PDIFF  = 22'h000800,
        S_PNEXT  = 22'h001000,
        S_DIV1   = 22'h002000,
        S_DIV1W  = 22'h004000,
        S_MEAN   = 22'h008000,
        S_DIV2   = 22'h010000,
        S_DIV2W  = 22'h020000,
        S_VPREP  = 22'h040000,
        S_VAR    = 22'h080000,
        S_RMS    = 22'h100000,
        S_FINAL  = 22'h200000
    } state_t;

    typedef enum logic [1:0] {
        MODE_SPEED,
        MODE_PAIR,
        MODE_STAT
    } mode_t;

    state_t state_reg;
    state_t state_next;
    mode_t  mode_reg;
    mode_t  mode_next;
    logic   sel_reg;
    logic   sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_SPEED;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        sel_next     = sel_reg;
        cmd.op       = OP_NOP;
        cmd.sel_dist = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_LOADED;
                end
            end
            S_LOADED:
            begin
                if (stat.stored)
                begin
                    mode_next  = MODE_SPEED;
                    sel_next   = 1'b0;
                    state_next = S_SQX;
                end
                else if (stat.last)
                begin
                    state_next = S_WINIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SQX:
            begin
                cmd.op     = OP_SQX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = OP_SQY;
                state_next = (mode_reg == MODE_PAIR) ? S_PCHK : S_RT;
            end
            S_PCHK:
            begin
                state_next = stat.qualify ? S_RT : S_PNEXT;
            end
            S_RT:
            begin
                cmd.op     = OP_RT_GO;
                state_next = S_RTW;
            end
            S_RTW:
            begin
                if (!stat.sqrt_busy)
                begin
                    state_next = (mode_reg == MODE_STAT) ? S_RMS : S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = S_ACCSQ;
            end
            S_ACCSQ:
            begin
                cmd.op = OP_ACCSQ;
                if (mode_reg == MODE_PAIR)
                begin
                    state_next = S_PNEXT;
                end
                else
                begin
                    state_next = stat.last ? S_WINIT : S_IDLE;
                end
            end
            S_WINIT:
            begin
                cmd.op = OP_WINIT;
                if (stat.cnt_ge2)
                begin
                    mode_next  = MODE_PAIR;
                    sel_next   = 1'b1;
                    state_next = S_PRD;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_PRD:
            begin
                cmd.op     = OP_PRD;
                state_next = S_PDIFF;
            end
            S_PDIFF:
            begin
                cmd.op     = OP_PDIFF;
                state_next = S_SQX;
            end
            S_PNEXT:
            begin
                cmd.op = OP_PNEXT;
                if (stat.walk_end)
                begin
                    mode_next  = MODE_STAT;
                    sel_next   = 1'b0;
                    state_next = S_DIV1;
                end
                else
                begin
                    state_next = S_PRD;
                end
            end
            S_DIV1:
            begin
                cmd.op     = OP_DIV_SUM;
                state_next = S_DIV1W;
            end
            S_DIV1W:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.op     = OP_MEAN;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.op     = OP_DIV_SQ;
                state_next = S_DIV2W;
            end
            S_DIV2W:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_VPREP;
                end
            end
            S_VPREP:
            begin
                cmd.op     = OP_VPREP;
                state_next = S_VAR;
            end
            S_VAR:
            begin
                cmd.op     = OP_VAR;
                state_next = S_RT;
            end
            S_RMS:
            begin
                cmd.op = OP_RMS;
                if (!sel_reg && stat.has_pairs)
                begin
                    sel_next   = 1'b1;
                    state_next = S_DIV1;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_tready = (state_reg == S_IDLE);

endmodule

FILE: rtl/core/neighbour_distance_speed_stats_core.sv
// Top level: neighbour distance and speed statistics over a set of agents.
//
// Input stream: one agent per word (position, velocity); tlast marks the
// final agent of a set. Output stream: one word per set, sent after the
// word carrying tlast. cfg_we/cfg_wdata write the neighbour radius (Q13.4).
// Each agent goes through a squarer pass and the 17-step root unit;
// an agent beyond capacity is not stored and sets tuser. After tlast
// the pair walk visits each pair, and a pair inside the radius goes
// through the root unit again; then each statistic set costs two
// passes of the 53-step divider and one root, done for speed when the
// set holds two or more agents, and for distance when any pair was counted.
// The whole set is handled one stage at a time by a single controller.
// A new agent is accepted while a finished result waits in the output
// register; a further result waits until the receiver takes that word.
// Reset clears the set, restores the radius to 1600 and empties the output;
// stored positions are not cleared.
module neighbour_distance_speed_stats_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y
    input  logic [nds_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // mean_distance, rms_distance, mean_speed, rms_speed, pair_count, zero pad
    output logic [nds_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // overflowed
    output logic                             m_axis_tuser,
    input  logic                             cfg_we,
    input  logic [nds_pkg::RAD_W-1:0]        cfg_wdata
);
    import nds_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    nds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    nds_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_tdata   (s_axis_tdata),
        .in_tlast   (s_axis_tlast),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser)
    );

endmodule

FILE: rtl/core/nds_checker.sv
// Port-level checker for the statistics core, bound to the top level.
`include "assert_macros.svh"

module nds_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [nds_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);
    import nds_pkg::*;

    logic no_pairs;
    logic dist_zero;

    assign no_pairs  = (m_axis_tdata[84:66] == '0);
    assign dist_zero = (m_axis_tdata[33:0] == '0);

    // a stalled result word holds
    `NDS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // output register empty straight out of reset
    `NDS_ASSERT_NOW(a_rst_empty, clk, rst_n, $rose(rst_n), !m_axis_tvalid)

    // input stalls after the last agent of a set is taken
    `NDS_ASSERT_NEXT(a_last_busy, clk, rst_n,
                     s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

    // no counted pair means zero distance statistics
    `NDS_ASSERT_NOW(a_nopair_zero, clk, rst_n, m_axis_tvalid && no_pairs, dist_zero)

endmodule

bind neighbour_distance_speed_stats_core nds_checker u_nds_checker (.*);
